### rtl/gbpf_pkg.sv
// Shared constants, payload types and codes of the grid breadth-first path finder.
package gbpf_pkg;

  localparam int unsigned MAX_WIDTH  = 32;
  localparam int unsigned MAX_HEIGHT = 32;
  localparam int unsigned COORD_W    = 5;
  localparam int unsigned DIM_W      = 6;
  localparam int unsigned CELL_W     = 2 * COORD_W;
  localparam int unsigned NUM_CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned PTR_W      = CELL_W + 1;
  localparam int unsigned MAX_PATH   = 62;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = DIM_W;
  localparam int unsigned DIM_RESET  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_YP = 2'd0,
    DIR_YM = 2'd1,
    DIR_XP = 2'd2,
    DIR_XM = 2'd3
  } dir_e;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               is_cell;
    logic               found;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } grid_dims_t;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic              pop;
    logic [CELL_W-1:0] push_data;
  } fifo_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic [CELL_W-1:0] rdata;
  } fifo_stat_t;

endpackage

### rtl/gbpf_if.sv
// Valid/ready channel interfaces for requests and results.
interface gbpf_req_if;
  import gbpf_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gbpf_res_if;
  import gbpf_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/grid_bfs_path_finder.sv
// Top level of the grid breadth-first path finder: configuration, search engine and checks.
//
// Each request transaction names a start cell and a goal cell on an obstacle-free grid of
// grid_width columns by grid_height rows (register values above 32 count as 32). The block
// answers with the shortest path from the goal back toward the start, goal first and start
// excluded, one result transaction per cell, with last set on the cell next to the start.
// A request with a coordinate off the grid gives one status transaction with found low; a
// request whose start equals its goal gives one status transaction with found high. The
// block takes one request at a time and accepts the next once the previous one has handed
// its final result to the output register. A search first clears all 1024 entries of the
// cell memory, one entry per cycle, during which no request is taken; it then checks the
// neighbors of each dequeued cell, each on-grid check being a read of the cell memory and,
// for an unvisited cell, a write; the walk-back then reads each path cell from the cell
// memory before it emits it. Configuration writes belong between requests, while the
// block is idle.
module grid_bfs_path_finder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gbpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gbpf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  gbpf_req_if.sink                             req_i,
  gbpf_res_if.source                           res_o
);
  import gbpf_pkg::*;

  logic [DIM_W-1:0] grid_width_q, grid_height_q;
  grid_dims_t       dims;
  logic             busy;

  // Grid size registers; a write picks its register by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_W'(DIM_RESET);
      grid_height_q <= DIM_W'(DIM_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GRID_WIDTH) begin
        grid_width_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_GRID_HEIGHT) begin
        grid_height_q <= cfg_wdata_i;
      end
    end
  end

  // Saturate the size to the grid the memories hold. A size of zero leaves no valid cell.
  assign dims.width  = (grid_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width_q;
  assign dims.height = (grid_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                            : grid_height_q;

  gbpf_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dims_i (dims),
    .req_i  (req_i),
    .res_o  (res_o),
    .busy_o (busy)
  );

  // A status-only transaction is always the final one of its request.
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.data.is_cell |-> res_o.data.last)
    else $error("status transaction without last");

  // A status-only transaction carries zero coordinates.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.data.is_cell |-> res_o.data.cell_x == '0 && res_o.data.cell_y == '0)
    else $error("status transaction with nonzero coordinates");

  // Every path cell comes from a search that reached its goal.
  a_cell_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.is_cell |-> res_o.data.found)
    else $error("path cell without found");

  // An accepted request keeps the engine busy in the following cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> busy && !req_i.ready)
    else $error("engine not busy after request");

endmodule

### rtl/gbpf_fifo.sv
// Search queue: a 1024-entry memory of cell indexes with head and tail pointers.
module gbpf_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gbpf_pkg::fifo_ctrl_t   ctrl_i,
  output gbpf_pkg::fifo_stat_t   stat_o
);
  import gbpf_pkg::*;

  logic [CELL_W-1:0] mem [NUM_CELLS];
  logic [PTR_W-1:0]  head_q, tail_q;
  logic [CELL_W-1:0] rdata_q;
  logic              can_push;

  // The tail stops at the depth; every cell is queued at most once per search.
  assign can_push = ctrl_i.push && !tail_q[PTR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (ctrl_i.clear) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (can_push) begin
        tail_q <= tail_q + PTR_W'(1);
      end
      if (ctrl_i.pop) begin
        head_q <= head_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_push && !ctrl_i.clear) begin
      mem[tail_q[CELL_W-1:0]] <= ctrl_i.push_data;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem[head_q[CELL_W-1:0]];
    end
  end

  assign stat_o.empty = (head_q == tail_q);
  assign stat_o.rdata = rdata_q;

endmodule

### rtl/gbpf_search.sv
// Search sequencer: cell memory (visited and parent direction), BFS steps and path walk-back.
module gbpf_search (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gbpf_pkg::grid_dims_t   dims_i,
  gbpf_req_if.sink               req_i,
  gbpf_res_if.source             res_o,
  output logic                   busy_o
);
  import gbpf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_STATUS, S_CLEAR, S_SEED, S_FETCH, S_POP,
    S_NREAD, S_NCHK, S_WREAD, S_WEMIT
  } state_e;

  state_e             state_q;
  logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;
  logic [COORD_W-1:0] cur_x_q, cur_y_q;
  dir_e               dir_q;
  logic [CELL_W-1:0]  clr_q;
  logic [STEP_W-1:0]  step_q;
  logic               status_found_q;
  logic               res_valid_q;
  res_t               res_q;

  // Cell memory: bit 2 is the visited mark, bits 1:0 the direction of arrival.
  logic [2:0]         cell_mem [NUM_CELLS];
  logic [2:0]         cell_rdata_q;
  logic               cell_we, cell_re;
  logic [CELL_W-1:0]  cell_waddr, cell_raddr;
  logic [2:0]         cell_wdata;

  fifo_ctrl_t         fifo_ctrl;
  fifo_stat_t         fifo_stat;

  logic               nb_ok;
  logic [COORD_W-1:0] nb_x, nb_y;
  logic [CELL_W-1:0]  nb_idx;
  logic               nb_new, nb_goal;
  logic [DIM_W-1:0]   px, py;
  logic               at_start, walk_last, out_free, res_emit;
  logic               req_bad, req_same;

  gbpf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fifo_ctrl),
    .stat_o (fifo_stat)
  );

  // Neighbor of the current cell in the current direction, and whether it lies on the grid.
  always_comb begin
    nb_x  = cur_x_q;
    nb_y  = cur_y_q;
    nb_ok = 1'b0;
    unique case (dir_q)
      DIR_YP: begin
        nb_y  = cur_y_q + COORD_W'(1);
        nb_ok = ({1'b0, cur_y_q} + DIM_W'(1)) < dims_i.height;
      end
      DIR_YM: begin
        nb_y  = cur_y_q - COORD_W'(1);
        nb_ok = (cur_y_q != '0);
      end
      DIR_XP: begin
        nb_x  = cur_x_q + COORD_W'(1);
        nb_ok = ({1'b0, cur_x_q} + DIM_W'(1)) < dims_i.width;
      end
      DIR_XM: begin
        nb_x  = cur_x_q - COORD_W'(1);
        nb_ok = (cur_x_q != '0);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_idx  = {nb_y, nb_x};
  assign nb_new  = (state_q == S_NCHK) && !cell_rdata_q[2];
  assign nb_goal = nb_new && (nb_x == gx_q) && (nb_y == gy_q);

  // Parent of the walk position: step back against the direction of arrival.
  always_comb begin
    px = {1'b0, cur_x_q};
    py = {1'b0, cur_y_q};
    unique case (dir_e'(cell_rdata_q[1:0]))
      DIR_YP: py = (cur_y_q == '0) ? '0 : {1'b0, cur_y_q} - DIM_W'(1);
      DIR_YM: py = {1'b0, cur_y_q} + DIM_W'(1);
      DIR_XP: px = (cur_x_q == '0) ? '0 : {1'b0, cur_x_q} - DIM_W'(1);
      DIR_XM: px = {1'b0, cur_x_q} + DIM_W'(1);
      default: px = {1'b0, cur_x_q};
    endcase
  end

  assign at_start  = (px == {1'b0, sx_q}) && (py == {1'b0, sy_q});
  assign walk_last = at_start || (step_q == STEP_W'(MAX_PATH - 1));
  assign out_free  = !res_valid_q || res_o.ready;
  // A result enters the output register in this cycle.
  assign res_emit  = out_free && ((state_q == S_STATUS) || (state_q == S_WEMIT));

  assign req_bad  = ({1'b0, req_i.data.start_x} >= dims_i.width)
                 || ({1'b0, req_i.data.start_y} >= dims_i.height)
                 || ({1'b0, req_i.data.goal_x} >= dims_i.width)
                 || ({1'b0, req_i.data.goal_y} >= dims_i.height);
  assign req_same = (req_i.data.start_x == req_i.data.goal_x)
                 && (req_i.data.start_y == req_i.data.goal_y);

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = nb_idx;
    cell_wdata = {1'b1, dir_q};
    cell_re    = 1'b0;
    cell_raddr = nb_idx;
    fifo_ctrl  = '{clear: 1'b0, push: 1'b0, pop: 1'b0, push_data: nb_idx};
    unique case (state_q)
      S_CLEAR: begin
        cell_we         = 1'b1;
        cell_waddr      = clr_q;
        cell_wdata      = '0;
        fifo_ctrl.clear = 1'b1;
      end
      S_SEED: begin
        cell_we             = 1'b1;
        cell_waddr          = {sy_q, sx_q};
        cell_wdata          = {1'b1, DIR_YP};
        fifo_ctrl.push      = 1'b1;
        fifo_ctrl.push_data = {sy_q, sx_q};
      end
      S_FETCH: fifo_ctrl.pop = !fifo_stat.empty;
      S_NREAD: cell_re = nb_ok;
      S_NCHK: begin
        cell_we        = nb_new;
        fifo_ctrl.push = nb_new;
      end
      S_WREAD: begin
        cell_re    = 1'b1;
        cell_raddr = {cur_y_q, cur_x_q};
      end
      default: cell_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      if (res_emit) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            sx_q <= req_i.data.start_x;
            sy_q <= req_i.data.start_y;
            gx_q <= req_i.data.goal_x;
            gy_q <= req_i.data.goal_y;
            clr_q <= '0;
            if (req_bad) begin
              status_found_q <= 1'b0;
              state_q        <= S_STATUS;
            end else if (req_same) begin
              status_found_q <= 1'b1;
              state_q        <= S_STATUS;
            end else begin
              state_q <= S_CLEAR;
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            res_q       <= '{cell_x: '0, cell_y: '0, is_cell: 1'b0,
                             found: status_found_q, last: 1'b1};
            state_q     <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + CELL_W'(1);
          if (clr_q == CELL_W'(NUM_CELLS - 1)) begin
            state_q <= S_SEED;
          end
        end
        S_SEED: state_q <= S_FETCH;
        S_FETCH: begin
          if (fifo_stat.empty) begin
            status_found_q <= 1'b0;
            state_q        <= S_STATUS;
          end else begin
            state_q <= S_POP;
          end
        end
        S_POP: begin
          cur_x_q <= fifo_stat.rdata[COORD_W-1:0];
          cur_y_q <= fifo_stat.rdata[CELL_W-1:COORD_W];
          dir_q   <= DIR_YP;
          state_q <= S_NREAD;
        end
        S_NREAD: begin
          if (nb_ok) begin
            state_q <= S_NCHK;
          end else if (dir_q == DIR_XM) begin
            state_q <= S_FETCH;
          end else begin
            dir_q <= dir_e'(dir_q + 2'd1);
          end
        end
        S_NCHK: begin
          if (nb_goal) begin
            cur_x_q <= gx_q;
            cur_y_q <= gy_q;
            step_q  <= '0;
            state_q <= S_WREAD;
          end else if (dir_q == DIR_XM) begin
            state_q <= S_FETCH;
          end else begin
            dir_q   <= dir_e'(dir_q + 2'd1);
            state_q <= S_NREAD;
          end
        end
        S_WREAD: state_q <= S_WEMIT;
        S_WEMIT: begin
          if (out_free) begin
            res_q       <= '{cell_x: cur_x_q, cell_y: cur_y_q, is_cell: 1'b1,
                             found: 1'b1, last: walk_last};
            if (walk_last) begin
              state_q <= S_IDLE;
            end else begin
              cur_x_q <= px[COORD_W-1:0];
              cur_y_q <= py[COORD_W-1:0];
              step_q  <= step_q + STEP_W'(1);
              state_q <= S_WREAD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;
  assign busy_o      = (state_q != S_IDLE);

endmodule

### test/tb_grid_bfs_path_finder.sv
// Self-checking testbench: breadth-first path search requests against a built-in path predictor.
`timescale 1ns / 1ps

module tb_grid_bfs_path_finder;
  import gbpf_pkg::*;

  // Slowest correct run of this stimulus is dominated by the per-request clearing pass and
  // the full-size grid searches; the limit lies well above it.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gbpf_req_if req_if ();
  gbpf_res_if res_if ();

  grid_bfs_path_finder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // Predictor state: our copy of the two grid registers, and the scratch stores of the
  // search. The visited marks are cleared for every request, exactly as the block does.
  logic [DIM_W-1:0]  grid_w_q = DIM_W'(DIM_RESET);
  logic [DIM_W-1:0]  grid_h_q = DIM_W'(DIM_RESET);
  bit                visited[NUM_CELLS];
  dir_e              came_from[NUM_CELLS];
  logic [CELL_W-1:0] bfs_queue[NUM_CELLS];

  // Path cells and status items still owed by the block, oldest first.
  res_t        path_q[$];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  // Random idling on both channels; switched off for the last part of the run.
  bit          idle_en   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Text form of one result transaction for the mismatch reports.
  function automatic string res_str(res_t r);
    return $sformatf("x=%0d y=%0d is_cell=%0b found=%0b last=%0b",
                     r.cell_x, r.cell_y, r.is_cell, r.found, r.last);
  endfunction

  // Works out every result transaction that one accepted request must produce and queues
  // them. The search visits neighbors in the order y+1, y-1, x+1, x-1 and remembers the
  // direction by which each cell was first reached; the path is then traced back from the
  // goal by undoing those directions until the start is the next cell.
  function automatic void predict_path(req_t r);
    int unsigned w, h, head, tail, goal, cur, ni;
    int          nx, ny, px, py, cx, cy;
    int          dx[4];
    int          dy[4];
    bit          at_start;
    dir_e        d;
    res_t        item;
    res_t        cells[$];
    dx = '{0, 0, 1, -1};
    dy = '{1, -1, 0, 0};
    // Register values beyond the largest grid count as the largest grid.
    w = (32'(grid_w_q) > MAX_WIDTH) ? MAX_WIDTH : 32'(grid_w_q);
    h = (32'(grid_h_q) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(grid_h_q);
    item = '0;
    item.last = 1'b1;
    foreach (visited[i]) visited[i] = 1'b0;

    // Any coordinate off the grid, which includes every request on a zero-sized grid,
    // gives a single status item with found low.
    if (32'(r.start_x) >= w || 32'(r.start_y) >= h || 32'(r.goal_x) >= w
        || 32'(r.goal_y) >= h) begin
      path_q.push_back(item);
      return;
    end
    // Start equal to goal gives a single status item with found high.
    if (r.start_x == r.goal_x && r.start_y == r.goal_y) begin
      item.found = 1'b1;
      path_q.push_back(item);
      return;
    end

    goal = 32'({r.goal_y, r.goal_x});
    visited[{r.start_y, r.start_x}] = 1'b1;
    bfs_queue[0] = {r.start_y, r.start_x};
    head = 0;
    tail = 1;
    while (head < tail && !visited[goal]) begin
      cur = 32'(bfs_queue[head]);
      head++;
      for (int k = 0; k < 4; k++) begin
        nx = int'(cur % MAX_WIDTH) + dx[k];
        ny = int'(cur / MAX_WIDTH) + dy[k];
        if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
        ni = ny * MAX_WIDTH + nx;
        if (visited[ni]) continue;
        visited[ni]   = 1'b1;
        came_from[ni] = dir_e'(k);
        bfs_queue[tail] = ni[CELL_W-1:0];
        tail++;
      end
    end

    // Without obstacles the goal is always reached, but an exhausted search would
    // answer with a status item with found low.
    if (!visited[goal]) begin
      path_q.push_back(item);
      return;
    end

    cx = int'(r.goal_x);
    cy = int'(r.goal_y);
    at_start = 1'b0;
    for (int s = 0; s < MAX_PATH && !at_start; s++) begin
      d  = came_from[cy * MAX_WIDTH + cx];
      px = cx - dx[d];
      py = cy - dy[d];
      if (px < 0) px = 0;
      if (py < 0) py = 0;
      at_start     = (px == int'(r.start_x) && py == int'(r.start_y));
      item.cell_x  = cx[COORD_W-1:0];
      item.cell_y  = cy[COORD_W-1:0];
      item.is_cell = 1'b1;
      item.found   = 1'b1;
      item.last    = at_start;
      cells.push_back(item);
      cx = px & 31;
      cy = py & 31;
    end
    // A walk cut off at the path length limit still ends the request.
    cells[$].last = 1'b1;
    foreach (cells[i]) path_q.push_back(cells[i]);
  endfunction

  // Offers one request, with an occasional gap in front of it, and holds it until the
  // block takes it. The expected results are queued at the edge of the transaction.
  // Valid stays high after acceptance; the next call or the drain decides at the next
  // falling edge, so valid never sees two assignments in one time step.
  task automatic send_request(input logic [COORD_W-1:0] sx, sy, gx, gy);
    req_t r;
    r = '{start_x: sx, start_y: sy, goal_x: gx, goal_y: gy};
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predict_path(r);
  endtask

  // Stops offering requests and waits until every owed result has come back, so that
  // the block is idle and a register write is safe.
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (path_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes both grid registers, one per cycle, and updates the predictor's copy.
  task automatic set_grid(input logic [DIM_W-1:0] w, h);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_GRID_WIDTH;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_GRID_HEIGHT;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    grid_w_q = w;
    grid_h_q = h;
  endtask

  // Reset grid of 16 by 16: the two far corners in both directions, which gives the
  // longest path there, and a single step in each of the four neighbor directions.
  task automatic test_basic_moves();
    send_request(5'd0, 5'd0, 5'd15, 5'd15);
    send_request(5'd15, 5'd15, 5'd0, 5'd0);
    send_request(5'd3, 5'd4, 5'd3, 5'd5);
    send_request(5'd3, 5'd5, 5'd3, 5'd4);
    send_request(5'd7, 5'd7, 5'd8, 5'd7);
    send_request(5'd8, 5'd7, 5'd7, 5'd7);
    wait_idle();
  endtask

  // Status-only answers: start equal to goal, each kind of coordinate off the grid, and
  // grids with no columns or no rows at all.
  task automatic test_status_items();
    send_request(5'd5, 5'd5, 5'd5, 5'd5);
    send_request(5'd16, 5'd0, 5'd0, 5'd0);
    send_request(5'd0, 5'd0, 5'd3, 5'd31);
    send_request(5'd31, 5'd31, 5'd31, 5'd31);
    wait_idle();
    set_grid(6'd0, 6'd16);
    send_request(5'd0, 5'd0, 5'd1, 5'd1);
    wait_idle();
    set_grid(6'd16, 6'd0);
    send_request(5'd0, 5'd0, 5'd0, 5'd0);
    wait_idle();
  endtask

  // Register values above 32 saturate to the full grid; corner to corner is the longest
  // possible path of 62 cells and drives every coordinate bit of the results.
  task automatic test_saturated_grid();
    set_grid(6'd63, 6'd33);
    send_request(5'd0, 5'd0, 5'd31, 5'd31);
    send_request(5'd31, 5'd31, 5'd0, 5'd0);
    send_request(5'd31, 5'd0, 5'd0, 5'd31);
    send_request(5'd31, 5'd31, 5'd31, 5'd31);
    wait_idle();
  endtask

  // One-column and one-row grids, where only one neighbor direction pair exists, and
  // the single-cell grid.
  task automatic test_thin_grids();
    set_grid(6'd1, 6'd32);
    send_request(5'd0, 5'd0, 5'd0, 5'd31);
    send_request(5'd0, 5'd5, 5'd1, 5'd5);
    wait_idle();
    set_grid(6'd32, 6'd1);
    send_request(5'd31, 5'd0, 5'd0, 5'd0);
    wait_idle();
    set_grid(6'd1, 6'd1);
    send_request(5'd0, 5'd0, 5'd0, 5'd0);
    send_request(5'd0, 5'd0, 5'd0, 5'd1);
    wait_idle();
  endtask

  // Ten phases of ten requests, each phase on a fresh random grid. Most grids are small
  // to keep the searches short; one phase uses the full grid through a value of 32 to 63.
  // Most requests lie on the grid, some repeat the start as the goal, and the rest take
  // fully random coordinates. The last two phases run without any idling.
  task automatic test_random_traffic();
    logic [COORD_W-1:0] sx, sy, gx, gy;
    logic [DIM_W-1:0]   w, h;
    int unsigned        ew, eh;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 7) begin
        w = DIM_W'($urandom_range(32, 63));
        h = DIM_W'($urandom_range(32, 63));
      end else begin
        w = DIM_W'($urandom_range(1, 12));
        h = DIM_W'($urandom_range(1, 12));
      end
      ew = (32'(w) > MAX_WIDTH) ? MAX_WIDTH : 32'(w);
      eh = (32'(h) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(h);
      idle_en = (phase < 8);
      set_grid(w, h);
      for (int n = 0; n < 10; n++) begin
        sx = COORD_W'($urandom_range(0, ew - 1));
        sy = COORD_W'($urandom_range(0, eh - 1));
        gx = COORD_W'($urandom_range(0, ew - 1));
        gy = COORD_W'($urandom_range(0, eh - 1));
        case ($urandom_range(0, 15))
          0, 1: begin
            sx = COORD_W'($urandom_range(0, 31));
            sy = COORD_W'($urandom_range(0, 31));
            gx = COORD_W'($urandom_range(0, 31));
            gy = COORD_W'($urandom_range(0, 31));
          end
          2: begin
            gx = sx;
            gy = sy;
          end
          default: ;
        endcase
        send_request(sx, sy, gx, gy);
      end
      wait_idle();
    end
  endtask

  // Result side: random bursts of stall while idling is on.
  initial begin : result_stall
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Every result transaction is compared with the oldest owed result.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (path_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result: %s", res_str(res_if.data));
      end else begin
        want = path_q.pop_front();
        if (res_if.data !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("result mismatch: expected %s, got %s",
                     res_str(want), res_str(res_if.data));
        end
      end
    end
  end

  // Hung handshakes end the run here.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_seq
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_GRID_WIDTH;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_moves();
    test_status_items();
    test_saturated_grid();
    test_thin_grids();
    test_random_traffic();

    // Everything owed has arrived; give a stray extra result time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
